FILE: rtl/ils_pkg.sv
// ils_pkg: sizes, function and status codes, payload and RAM port types
// for the indexed list store. No dependencies.
`timescale 1ns / 1ps

package ils_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;

    localparam int ELEM_W = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = (CNT_W > 5) ? CNT_W : 5;

    localparam logic [3:0] FN_INS_HEAD = 4'd0;
    localparam logic [3:0] FN_INS_TAIL = 4'd1;
    localparam logic [3:0] FN_INS_AT   = 4'd2;
    localparam logic [3:0] FN_RM_HEAD  = 4'd3;
    localparam logic [3:0] FN_RM_TAIL  = 4'd4;
    localparam logic [3:0] FN_RM_AT    = 4'd5;
    localparam logic [3:0] FN_READ     = 4'd6;
    localparam logic [3:0] FN_REPLACE  = 4'd7;
    localparam logic [3:0] FN_SEARCH   = 4'd8;
    localparam logic [3:0] FN_COMPARE  = 4'd9;
    localparam logic [3:0] FN_SWAP     = 4'd10;
    localparam logic [3:0] FN_CLEAR    = 4'd11;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;
    localparam logic [1:0] STAT_FULL  = 2'd3;

    typedef struct packed {
        logic [3:0]  func;
        logic [31:0] value;
        logic [4:0]  index;
        logic [3:0]  second_index;
    } req_t;

    typedef struct packed {
        logic [31:0] read_value;
        logic        found;
        logic [1:0]  status;
        logic [4:0]  count;
        logic        is_empty;
    } rsp_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [ELEM_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SHIFT_UP,
        S_SHIFT_DN,
        S_READ,
        S_SEARCH,
        S_SWAP_B,
        S_SWAP_WA,
        S_SWAP_WB,
        S_DONE
    } eng_state_t;

endpackage

FILE: rtl/indexed_list_store.sv
// indexed_list_store: top level; sequencer, element RAM and response register.
// Depends on ils_pkg, ils_ram, ils_engine.
//
//   channel  | signals                       | transfer when
//   ---------+-------------------------------+----------------------------
//   request  | req_valid, req_ready, req     | req_valid && req_ready
//   response | rsp_valid, rsp_ready, rsp     | rsp_valid && rsp_ready
//
// One request in flight. Inserts and removes shift the list one element a cycle
// through the one RAM read and one RAM write port.
// Reset empties the list; element storage is not cleared.
// A finished response waits in the output register while the next request
// is taken; the sequencer holds in its last step only if that register is full.
`timescale 1ns / 1ps

module indexed_list_store (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  ils_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output ils_pkg::rsp_t rsp
);

    import ils_pkg::*;

    ram_req_t          ram;
    logic [ELEM_W-1:0] rdata;
    logic              res_valid;
    logic              res_ready;
    rsp_t              res;
    logic              rsp_valid_reg;
    rsp_t              rsp_reg;

    ils_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram.we),
        .waddr (ram.waddr),
        .wdata (ram.wdata),
        .raddr (ram.raddr),
        .rdata (rdata)
    );

    ils_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .ram       (ram),
        .rdata     (rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !rsp_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (res_ready)
            rsp_valid_reg <= res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
            rsp_reg <= res;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while sequencer busy");

    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready |=> rsp_valid)
        else $error("finished result not registered");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == STAT_FULL |-> rsp.count == 5'(DEPTH))
        else $error("full status with list not full");

    a_err_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != STAT_OK |-> rsp.read_value == '0 && !rsp.found)
        else $error("data returned on failed request");

endmodule

FILE: rtl/ils_ram.sv
// ils_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ils_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/ils_engine.sv
// ils_engine: request sequencer; walks the element RAM one entry per cycle
// for shifts and searches through one shared equality compare.
// Depends on ils_pkg.
`timescale 1ns / 1ps

module ils_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  ils_pkg::req_t     req,
    output ils_pkg::ram_req_t ram,
    input  logic [ils_pkg::ELEM_W-1:0] rdata,
    output logic              res_valid,
    input  logic              res_ready,
    output ils_pkg::rsp_t     res
);

    import ils_pkg::*;

    eng_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [3:0]        func_reg, func_next;
    logic [ELEM_W-1:0] val_reg, val_next;
    logic [CNT_W-1:0]  p_reg, p_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic [ADDR_W-1:0] idx2_reg, idx2_next;
    logic              hit_reg, hit_next;
    logic [ELEM_W-1:0] rd_reg, rd_next;
    logic [1:0]        stat_reg, stat_next;
    logic [ELEM_W-1:0] tmp_reg, tmp_next;
    logic              pend_reg, pend_next;

    logic              eq;
    logic [ELEM_W-1:0] v_in;
    logic [IDX_W-1:0]  idx_ext, idx2_ext, fill_ext;

    assign eq       = (rdata == val_reg);
    assign v_in     = req.value[ELEM_W-1:0];
    assign idx_ext  = IDX_W'(req.index);
    assign idx2_ext = IDX_W'(req.second_index);
    assign fill_ext = IDX_W'(fill_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        val_reg  <= val_next;
        p_reg    <= p_next;
        ptr_reg  <= ptr_next;
        idx2_reg <= idx2_next;
        hit_reg  <= hit_next;
        rd_reg   <= rd_next;
        stat_reg <= stat_next;
        tmp_reg  <= tmp_next;
        pend_reg <= pend_next;
    end

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        func_next  = func_reg;
        val_next   = val_reg;
        p_next     = p_reg;
        ptr_next   = ptr_reg;
        idx2_next  = idx2_reg;
        hit_next   = hit_reg;
        rd_next    = rd_reg;
        stat_next  = stat_reg;
        tmp_next   = tmp_reg;
        pend_next  = pend_reg;
        ram        = '0;
        req_ready  = 1'b0;
        res_valid  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    func_next  = req.func;
                    val_next   = v_in;
                    stat_next  = STAT_OK;
                    hit_next   = 1'b0;
                    rd_next    = '0;
                    pend_next  = 1'b0;
                    state_next = S_DONE;
                    unique case (req.func)
                        FN_INS_HEAD, FN_INS_TAIL, FN_INS_AT:
                        begin
                            priority if (fill_reg == CNT_W'(DEPTH))
                            begin
                                stat_next = STAT_FULL;
                            end
                            else if (req.func == FN_INS_AT && idx_ext > fill_ext)
                            begin
                                stat_next = STAT_RANGE;
                            end
                            else
                            begin
                                priority if (req.func == FN_INS_HEAD)
                                    p_next = '0;
                                else if (req.func == FN_INS_TAIL)
                                    p_next = fill_reg;
                                else
                                    p_next = CNT_W'(req.index);
                                ptr_next   = fill_reg;
                                ram.raddr  = ADDR_W'(fill_reg - CNT_W'(1));
                                state_next = S_SHIFT_UP;
                            end
                        end
                        FN_RM_HEAD, FN_RM_TAIL, FN_RM_AT, FN_READ, FN_REPLACE,
                        FN_COMPARE, FN_SWAP:
                        begin
                            priority if (fill_reg == '0)
                            begin
                                stat_next = STAT_EMPTY;
                            end
                            else if (req.func == FN_RM_HEAD)
                            begin
                                ptr_next   = '0;
                                ram.raddr  = ADDR_W'(1);
                                state_next = S_SHIFT_DN;
                            end
                            else if (req.func == FN_RM_TAIL)
                            begin
                                fill_next = fill_reg - CNT_W'(1);
                            end
                            else if (req.func == FN_SWAP)
                            begin
                                if (idx_ext >= fill_ext || idx2_ext >= fill_ext)
                                begin
                                    stat_next = STAT_RANGE;
                                end
                                else
                                begin
                                    p_next     = CNT_W'(req.index);
                                    idx2_next  = ADDR_W'(req.second_index);
                                    ram.raddr  = ADDR_W'(req.index);
                                    state_next = S_SWAP_B;
                                end
                            end
                            else if (idx_ext >= fill_ext)
                            begin
                                stat_next = STAT_RANGE;
                            end
                            else if (req.func == FN_RM_AT)
                            begin
                                ptr_next   = CNT_W'(req.index);
                                ram.raddr  = ADDR_W'(CNT_W'(req.index) + CNT_W'(1));
                                state_next = S_SHIFT_DN;
                            end
                            else if (req.func == FN_REPLACE)
                            begin
                                ram.we    = 1'b1;
                                ram.waddr = ADDR_W'(req.index);
                                ram.wdata = v_in;
                            end
                            else
                            begin
                                ram.raddr  = ADDR_W'(req.index);
                                state_next = S_READ;
                            end
                        end
                        FN_SEARCH:
                        begin
                            ptr_next   = '0;
                            state_next = S_SEARCH;
                        end
                        FN_CLEAR:
                        begin
                            fill_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SHIFT_UP:
            begin
                ram.we = 1'b1;
                if (ptr_reg == p_reg)
                begin
                    ram.waddr  = ADDR_W'(p_reg);
                    ram.wdata  = val_reg;
                    fill_next  = fill_reg + CNT_W'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    ram.waddr = ADDR_W'(ptr_reg);
                    ram.wdata = rdata;
                    ram.raddr = ADDR_W'(ptr_reg - CNT_W'(2));
                    ptr_next  = ptr_reg - CNT_W'(1);
                end
            end
            S_SHIFT_DN:
            begin
                if (ptr_reg + CNT_W'(1) == fill_reg)
                begin
                    fill_next  = fill_reg - CNT_W'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    ram.we    = 1'b1;
                    ram.waddr = ADDR_W'(ptr_reg);
                    ram.wdata = rdata;
                    ram.raddr = ADDR_W'(ptr_reg + CNT_W'(2));
                    ptr_next  = ptr_reg + CNT_W'(1);
                end
            end
            S_READ:
            begin
                if (func_reg == FN_READ)
                    rd_next = rdata;
                else
                    hit_next = eq;
                state_next = S_DONE;
            end
            S_SEARCH:
            begin
                // compare checks the read issued in the cycle before
                hit_next = hit_reg | (pend_reg & eq);
                if (ptr_reg < fill_reg)
                begin
                    ram.raddr = ptr_reg[ADDR_W-1:0];
                    ptr_next  = ptr_reg + CNT_W'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_DONE;
                end
            end
            S_SWAP_B:
            begin
                tmp_next   = rdata;
                ram.raddr  = idx2_reg;
                state_next = S_SWAP_WA;
            end
            S_SWAP_WA:
            begin
                ram.we     = 1'b1;
                ram.waddr  = ADDR_W'(p_reg);
                ram.wdata  = rdata;
                state_next = S_SWAP_WB;
            end
            S_SWAP_WB:
            begin
                ram.we     = 1'b1;
                ram.waddr  = idx2_reg;
                ram.wdata  = tmp_reg;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.read_value = 32'(rd_reg);
        res.found      = hit_reg;
        res.status     = stat_reg;
        res.count      = 5'(fill_reg);
        res.is_empty   = (fill_reg == '0);
    end

endmodule

FILE: verif/ils_list_checker.sv
// ils_list_checker: watches both channels of indexed_list_store, predicts each
// response from its own list model and compares. Depends on ils_pkg.
`timescale 1ns / 1ps

module ils_list_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_ready,
    input  ils_pkg::req_t req,
    input  logic          rsp_valid,
    input  logic          rsp_ready,
    input  ils_pkg::rsp_t rsp,
    output int            mismatches,
    output int            outstanding
);

    import ils_pkg::*;

    logic [31:0] list_elems [DEPTH];
    int          list_fill;
    rsp_t        rsp_due [$];
    int          err_cnt;

    function automatic rsp_t apply_request(input req_t r);
        rsp_t        o;
        int          pos;
        int          k;
        logic [31:0] t;
        o = '0;
        case (r.func)
            FN_INS_HEAD, FN_INS_TAIL, FN_INS_AT:
            begin
                if (list_fill >= DEPTH)
                begin
                    o.status = STAT_FULL;
                end
                else if (r.func == FN_INS_AT && int'(r.index) > list_fill)
                begin
                    o.status = STAT_RANGE;
                end
                else
                begin
                    if (r.func == FN_INS_HEAD)
                        pos = 0;
                    else if (r.func == FN_INS_TAIL)
                        pos = list_fill;
                    else
                        pos = int'(r.index);
                    for (k = list_fill; k > pos; k--)
                        list_elems[k] = list_elems[k - 1];
                    list_elems[pos] = r.value;
                    list_fill++;
                end
            end
            FN_RM_HEAD, FN_RM_TAIL, FN_RM_AT, FN_READ, FN_REPLACE, FN_COMPARE, FN_SWAP:
            begin
                if (list_fill == 0)
                begin
                    o.status = STAT_EMPTY;
                end
                else if (r.func == FN_RM_TAIL)
                begin
                    list_fill--;
                end
                else if (r.func == FN_SWAP)
                begin
                    if (int'(r.index) >= list_fill || int'(r.second_index) >= list_fill)
                    begin
                        o.status = STAT_RANGE;
                    end
                    else
                    begin
                        t = list_elems[r.index];
                        list_elems[r.index] = list_elems[r.second_index];
                        list_elems[r.second_index] = t;
                    end
                end
                else if (r.func != FN_RM_HEAD && int'(r.index) >= list_fill)
                begin
                    o.status = STAT_RANGE;
                end
                else if (r.func == FN_RM_HEAD || r.func == FN_RM_AT)
                begin
                    pos = (r.func == FN_RM_HEAD) ? 0 : int'(r.index);
                    for (k = pos; k + 1 < list_fill; k++)
                        list_elems[k] = list_elems[k + 1];
                    list_fill--;
                end
                else if (r.func == FN_READ)
                begin
                    o.read_value = list_elems[r.index];
                end
                else if (r.func == FN_REPLACE)
                begin
                    list_elems[r.index] = r.value;
                end
                else
                begin
                    o.found = (list_elems[r.index] == r.value);
                end
            end
            FN_SEARCH:
            begin
                for (k = 0; k < list_fill; k++)
                    if (list_elems[k] == r.value)
                        o.found = 1'b1;
            end
            FN_CLEAR:
            begin
                list_fill = 0;
            end
            default:
            begin
            end
        endcase
        o.count    = 5'(list_fill);
        o.is_empty = (list_fill == 0);
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t exp_rsp;
        if (!rst_n)
        begin
            list_fill = 0;
            err_cnt   = 0;
            rsp_due.delete();
        end
        else
        begin
            if (req_valid && req_ready)
                rsp_due.push_back(apply_request(req));
            if (rsp_valid && rsp_ready)
            begin
                if (rsp_due.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("ils: response with none pending: rd=%h found=%b st=%0d cnt=%0d",
                                 rsp.read_value, rsp.found, rsp.status, rsp.count);
                end
                else
                begin
                    exp_rsp = rsp_due.pop_front();
                    if (rsp.read_value !== exp_rsp.read_value || rsp.found !== exp_rsp.found
                        || rsp.status !== exp_rsp.status || rsp.count !== exp_rsp.count
                        || rsp.is_empty !== exp_rsp.is_empty)
                    begin
                        err_cnt++;
                        if (err_cnt <= 10)
                        begin
                            $display("ils: mismatch exp rd=%h found=%b st=%0d cnt=%0d empty=%b",
                                     exp_rsp.read_value, exp_rsp.found, exp_rsp.status,
                                     exp_rsp.count, exp_rsp.is_empty);
                            $display("ils:          got rd=%h found=%b st=%0d cnt=%0d empty=%b",
                                     rsp.read_value, rsp.found, rsp.status,
                                     rsp.count, rsp.is_empty);
                        end
                    end
                end
            end
        end
        mismatches  <= err_cnt;
        outstanding <= rsp_due.size();
    end

endmodule

FILE: verif/indexed_list_store_tb.sv
// indexed_list_store_tb: drives directed then random list requests with random
// idling on both channels; verdict from ils_list_checker. Depends on ils_pkg.
`timescale 1ns / 1ps

module indexed_list_store_tb;

    import ils_pkg::*;

    localparam int RANDOM_ITEMS = 1025;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 40;

    localparam logic [3:0] FN_FIRST_UNUSED = FN_CLEAR + 4'd1;
    localparam logic [3:0] FN_LAST_UNUSED  = 4'hF;

    typedef enum logic [1:0] {MIX_GROW, MIX_ANY, MIX_DRAIN} mix_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    req_t        req       = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    rsp_t        rsp;
    logic        calm      = 1'b0;
    int          mismatches;
    int          outstanding;
    int          cycle_cnt = 0;
    logic [31:0] recent [8];

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    indexed_list_store i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    ils_list_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always @(posedge clk)
        rsp_ready <= calm || ($urandom_range(99) >= 6);

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_item(input logic [3:0] f, input logic [31:0] v,
                             input logic [4:0] ix, input logic [3:0] ix2);
        while (!calm && $urandom_range(99) < 6)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req       <= '{f, v, ix, ix2};
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    function automatic logic [3:0] pick_func(input mix_t m);
        int roll;
        roll = $urandom_range(99);
        case (m)
            MIX_GROW:
            begin
                if (roll < 65)
                    return 4'($urandom_range(FN_INS_AT, FN_INS_HEAD));
                else if (roll < 90)
                    return 4'($urandom_range(FN_SWAP, FN_READ));
                else
                    return 4'($urandom_range(FN_RM_AT, FN_RM_HEAD));
            end
            MIX_DRAIN:
            begin
                if (roll < 55)
                    return 4'($urandom_range(FN_RM_AT, FN_RM_HEAD));
                else if (roll < 80)
                    return 4'($urandom_range(FN_SWAP, FN_READ));
                else if (roll < 95)
                    return 4'($urandom_range(FN_INS_AT, FN_INS_HEAD));
                else if (roll < 98)
                    return FN_CLEAR;
                else
                    return 4'($urandom_range(FN_LAST_UNUSED, FN_FIRST_UNUSED));
            end
            default:
            begin
                if (roll < 4)
                    return 4'($urandom_range(FN_LAST_UNUSED, FN_FIRST_UNUSED));
                else
                    return 4'($urandom_range(FN_CLEAR, FN_INS_HEAD));
            end
        endcase
    endfunction

    initial
    begin
        int          n;
        int          k;
        logic [3:0]  f;
        logic [31:0] v;
        logic [4:0]  ix;
        mix_t        mode;

        for (k = 0; k < 8; k++)
            recent[k] = $urandom();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list
        send_item(FN_RM_HEAD, 32'h0, 5'd0, 4'd0);
        send_item(FN_RM_TAIL, 32'h0, 5'd0, 4'd0);
        send_item(FN_RM_AT, 32'h0, 5'd0, 4'd0);
        send_item(FN_READ, 32'h0, 5'd0, 4'd0);
        send_item(FN_REPLACE, 32'h1, 5'd0, 4'd0);
        send_item(FN_COMPARE, 32'h0, 5'd0, 4'd0);
        send_item(FN_SWAP, 32'h0, 5'd0, 4'd0);
        send_item(FN_SEARCH, 32'h0, 5'd0, 4'd0);
        send_item(FN_INS_AT, 32'h1, 5'd1, 4'd0);
        // build [0, 5a5a5a5a, ffffffff, a5a5a5a5]
        send_item(FN_INS_HEAD, 32'h0, 5'd0, 4'd0);
        send_item(FN_INS_TAIL, 32'hFFFF_FFFF, 5'd0, 4'd0);
        send_item(FN_INS_AT, 32'hA5A5_A5A5, 5'd2, 4'd0);
        send_item(FN_INS_AT, 32'h5A5A_5A5A, 5'd1, 4'd0);
        send_item(FN_READ, 32'h0, 5'(DEPTH), 4'd0);
        send_item(FN_READ, 32'h0, 5'd2, 4'd0);
        send_item(FN_COMPARE, 32'hA5A5_A5A5, 5'd3, 4'd0);
        send_item(FN_SEARCH, 32'hFFFF_FFFF, 5'd0, 4'd0);
        send_item(FN_SWAP, 32'h0, 5'd0, 4'd0);
        send_item(FN_SWAP, 32'h0, 5'd0, 4'd15);
        send_item(FN_SWAP, 32'h0, 5'd1, 4'd3);
        send_item(FN_REPLACE, 32'h1234_5678, 5'd3, 4'd0);
        send_item(FN_RM_AT, 32'h0, 5'd1, 4'd0);
        send_item(FN_RM_HEAD, 32'h0, 5'd0, 4'd0);
        send_item(FN_FIRST_UNUSED, 32'hFFFF_FFFF, 5'd0, 4'd0);
        send_item(FN_LAST_UNUSED, 32'h0, 5'd0, 4'd0);
        send_item(FN_CLEAR, 32'h0, 5'd0, 4'd0);

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            mode = mix_t'((n / 40) % 3);
            calm <= (n >= 300 && n < 450);
            if (n == 600)
            begin
                req_valid <= 1'b0;
                @(posedge clk);
                while (outstanding != 0)
                    @(posedge clk);
            end
            f  = pick_func(mode);
            v  = ($urandom_range(99) < 40) ? recent[$urandom_range(7)] : $urandom();
            ix = ($urandom_range(99) < 40) ? 5'($urandom_range(3)) : 5'($urandom_range(DEPTH));
            if (f <= FN_INS_AT || f == FN_REPLACE)
                recent[$urandom_range(7)] = v;
            send_item(f, v, ix, 4'($urandom_range(15)));
        end
        req_valid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
